// ===== rtl/cdt_pkg.sv =====
package cdt_pkg;

    localparam int TIMER_SLOTS = 8;
    localparam int READY_DEPTH = 8;
    localparam int SLOT_W  = $clog2(TIMER_SLOTS);
    localparam int READY_W = $clog2(READY_DEPTH);
    localparam int CNT_W   = $clog2(TIMER_SLOTS + 2);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_ADD_TIMER = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_ADD_READY = 2'd2,
        CMD_POP       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_POP_OVER   = 3'd1,
        ERR_READY_FULL = 3'd2,
        ERR_READY_BUSY = 3'd3,
        ERR_LIST_LOOP  = 3'd4,
        ERR_TABLE_FULL = 3'd5
    } err_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] task_id;
        logic [15:0] delay_ticks;
    } cmd_item_t;

    typedef struct packed {
        logic        task_valid;
        logic [15:0] ready_task;
        logic [2:0]  error_code;
        logic        halted;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WALK,
        ST_ADD_FIND,
        ST_TICK_WALK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/countdown_timer_list_with_ready_fifo.sv =====
// countdown timer list with ready queue
// s_axis: one command transaction per item; tdata = command[1:0], task_id[17:2],
// delay_ticks[33:18], zero padded to 40 bits.
// m_axis: one result transaction per command; tdata = task_valid[0],
// ready_task[16:1], error_code[19:17], halted[20], zero padded to 24 bits.
// a two-entry command queue decouples intake from the execution engine.
// add ready and pop do their work in the idle state and then pass to the
// done state; add timer walks the linked list one entry per cycle, plus a
// free-slot search over slots 1 to TIMER_SLOTS-1 when it reaches the end;
// tick visits one live entry per cycle. every command ends in the done
// state, which writes the result. the engine holds one command at a time
// and takes the next one in the idle state once the output register is free.
// reset clears the timer table, ready ring and fault code at once.
// a stalled m_axis holds the result; the engine takes no new command until the
// output register is free, and the queue then fills and drops s_axis_tready.
// after any fault every command returns the sticky error code with halted set.
module countdown_timer_list_with_ready_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command, task_id, delay_ticks
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // task_valid, ready_task, error_code, halted
);
    import cdt_pkg::*;

    cmd_item_t in_item, q_item;
    logic      q_valid, q_ready;
    result_t   res;

    assign in_item.command     = cmd_t'(s_axis_tdata[1:0]);
    assign in_item.task_id     = s_axis_tdata[17:2];
    assign in_item.delay_ticks = s_axis_tdata[33:18];

    cdt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (in_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    cdt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .r_valid (m_axis_tvalid),
        .r_ready (m_axis_tready),
        .r_data  (res)
    );

    assign m_axis_tdata = {3'b000, res.halted, res.error_code, res.ready_task,
                           res.task_valid};
endmodule

// ===== rtl/cdt_front.sv =====
module cdt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  cdt_pkg::cmd_item_t s_item,
    output logic              q_valid,
    input  logic              q_ready,
    output cdt_pkg::cmd_item_t q_item
);
    import cdt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_item_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]       cnt_reg, cnt_next;
    logic              push, pop;

    assign s_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wr_next  = push ? ((wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== rtl/cdt_back.sv =====
module cdt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  cdt_pkg::cmd_item_t q_item,
    output logic               r_valid,
    input  logic               r_ready,
    output cdt_pkg::result_t   r_data
);
    import cdt_pkg::*;

    logic [15:0]        task_reg  [TIMER_SLOTS];
    logic [15:0]        count_reg [TIMER_SLOTS];
    logic [SLOT_W-1:0]  link_reg  [TIMER_SLOTS];
    logic [15:0]        ring_reg  [READY_DEPTH];
    logic [READY_W-1:0] head_reg, tail_reg;
    logic [2:0]         fault_reg;
    state_t             state_reg, state_next;
    cmd_item_t          cur_reg;
    logic [SLOT_W-1:0]  now_reg, prev_reg, find_reg;
    logic [CNT_W-1:0]   steps_reg;
    logic               rv_reg;
    result_t            res_reg;

    logic               take;
    logic               halted;
    logic [SLOT_W-1:0]  now_link;
    logic [15:0]        dec;
    logic [READY_W-1:0] tail_inc, head_inc;
    logic               room;
    logic               pop_hit, pop_over, pop_ok;

    assign halted   = (fault_reg != ERR_NONE);
    assign now_link = link_reg[now_reg];
    assign dec      = count_reg[now_reg] - 16'd1;
    assign tail_inc = (tail_reg == READY_W'(READY_DEPTH-1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == READY_W'(READY_DEPTH-1)) ? '0 : head_reg + 1'b1;
    assign room     = !rv_reg || r_ready;
    assign q_ready  = (state_reg == ST_IDLE) && room;
    assign take     = q_valid && q_ready;
    assign r_valid  = rv_reg;
    assign r_data   = res_reg;

    assign pop_hit  = !halted && q_item.command == CMD_POP && ring_reg[head_reg] != '0;
    // the ring entry at tail is never the one just cleared here
    assign pop_over = (tail_reg == head_inc) && ring_reg[head_inc] != '0
                      && head_inc != head_reg;
    assign pop_ok   = pop_hit && !pop_over;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !halted && q_item.command == CMD_ADD_TIMER
                    && q_item.task_id != '0)
                    state_next = ST_ADD_WALK;
                else if (take && !halted && q_item.command == CMD_TICK)
                    state_next = ST_TICK_WALK;
                else if (take)
                    state_next = ST_DONE;
            end
            ST_ADD_WALK:
            begin
                if (task_reg[now_reg] != '0)
                begin
                    if (steps_reg == CNT_W'(TIMER_SLOTS))
                        state_next = ST_DONE;
                end
                else if (now_reg == '0 && steps_reg != '0)
                    state_next = ST_ADD_FIND;
                else
                    state_next = ST_DONE;
            end
            ST_ADD_FIND:
            begin
                if (task_reg[find_reg] == '0 || find_reg == SLOT_W'(TIMER_SLOTS-1))
                    state_next = ST_DONE;
            end
            ST_TICK_WALK:
            begin
                if (task_reg[now_reg] == '0 || steps_reg == CNT_W'(TIMER_SLOTS))
                    state_next = ST_DONE;
                else if (dec == '0 && ring_reg[tail_reg] != '0)
                    state_next = ST_DONE;
                else if (dec == '0 && tail_inc == head_reg && ring_reg[tail_inc] != '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fault_reg <= ERR_NONE;
            head_reg  <= '0;
            tail_reg  <= '0;
            rv_reg    <= 1'b0;
            cur_reg   <= '0;
            now_reg   <= '0;
            prev_reg  <= '0;
            find_reg  <= '0;
            steps_reg <= '0;
            res_reg   <= '0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                task_reg[i]  <= '0;
                count_reg[i] <= '0;
                link_reg[i]  <= '0;
            end
            for (int i = 0; i < READY_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rv_reg && r_ready)
                rv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        cur_reg   <= q_item;
                        now_reg   <= link_reg[0];
                        prev_reg  <= '0;
                        find_reg  <= SLOT_W'(1);
                        steps_reg <= '0;
                        if (pop_ok)
                            res_reg <= result_t'{task_valid: 1'b1,
                                                 ready_task: ring_reg[head_reg],
                                                 error_code: ERR_NONE,
                                                 halted: 1'b0};
                        else
                            res_reg <= '0;
                        if (!halted && q_item.command == CMD_ADD_READY
                            && q_item.task_id != '0)
                        begin
                            if (ring_reg[tail_reg] == '0)
                            begin
                                ring_reg[tail_reg] <= q_item.task_id;
                                tail_reg <= tail_inc;
                                if (tail_inc == head_reg && ring_reg[tail_inc] != '0)
                                    fault_reg <= ERR_READY_FULL;
                            end
                            else
                                fault_reg <= ERR_READY_BUSY;
                        end
                        else if (pop_hit)
                        begin
                            ring_reg[head_reg] <= '0;
                            head_reg <= head_inc;
                            if (pop_over)
                                fault_reg <= ERR_POP_OVER;
                        end
                    end
                end
                ST_ADD_WALK:
                begin
                    if (task_reg[now_reg] != '0)
                    begin
                        if (steps_reg == CNT_W'(TIMER_SLOTS))
                            fault_reg <= ERR_LIST_LOOP;
                        prev_reg  <= now_reg;
                        now_reg   <= now_link;
                        steps_reg <= steps_reg + 1'b1;
                    end
                    else if (!(now_reg == '0 && steps_reg != '0))
                    begin
                        link_reg[prev_reg]  <= (now_reg == '0) ? SLOT_W'(1) : now_reg;
                        task_reg[(now_reg == '0) ? SLOT_W'(1) : now_reg] <= cur_reg.task_id;
                        count_reg[(now_reg == '0) ? SLOT_W'(1) : now_reg] <=
                            cur_reg.delay_ticks;
                    end
                end
                ST_ADD_FIND:
                begin
                    if (task_reg[find_reg] == '0)
                    begin
                        link_reg[prev_reg]  <= find_reg;
                        task_reg[find_reg]  <= cur_reg.task_id;
                        count_reg[find_reg] <= cur_reg.delay_ticks;
                    end
                    else if (find_reg == SLOT_W'(TIMER_SLOTS-1))
                        fault_reg <= ERR_TABLE_FULL;
                    find_reg <= find_reg + 1'b1;
                end
                ST_TICK_WALK:
                begin
                    if (task_reg[now_reg] != '0)
                    begin
                        if (steps_reg == CNT_W'(TIMER_SLOTS))
                            fault_reg <= ERR_LIST_LOOP;
                        else
                        begin
                            steps_reg <= steps_reg + 1'b1;
                            count_reg[now_reg] <= dec;
                            if (dec != '0)
                            begin
                                prev_reg <= now_reg;
                                now_reg  <= now_link;
                            end
                            else if (ring_reg[tail_reg] != '0)
                                fault_reg <= ERR_READY_BUSY;
                            else
                            begin
                                ring_reg[tail_reg] <= task_reg[now_reg];
                                tail_reg <= tail_inc;
                                if (tail_inc == head_reg && ring_reg[tail_inc] != '0)
                                    fault_reg <= ERR_READY_FULL;
                                else
                                begin
                                    // unlink; walk resumes after the removed entry
                                    task_reg[now_reg] <= '0;
                                    link_reg[now_reg] <= '0;
                                    if (now_reg == prev_reg)
                                        link_reg[prev_reg] <= '0;
                                    else
                                        link_reg[prev_reg] <= now_link;
                                    now_reg <= (now_reg == prev_reg) ? '0 : now_link;
                                end
                            end
                        end
                    end
                end
                ST_DONE:
                begin
                    rv_reg  <= 1'b1;
                    res_reg <= result_t'{task_valid: res_reg.task_valid,
                                         ready_task: res_reg.ready_task,
                                         error_code: fault_reg,
                                         halted: halted};
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

// ===== rtl/cdt_checker.sv =====
module cdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import cdt_pkg::*;

    a_halt_matches : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[20] == (m_axis_tdata[19:17] != ERR_NONE)))
        else $error("halted flag disagrees with error code");

    a_valid_task : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[16:1] != 16'd0)
        else $error("popped task is zero");

    a_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[20] |=> !m_axis_tvalid || m_axis_tdata[20])
        else $error("halt did not stick");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule

bind countdown_timer_list_with_ready_fifo cdt_checker u_cdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
